FILE: src/pdf_pkg.sv
// Package for the Pareto dominance filter: widths, defaults, cell control
// struct and the dominance test used by every cell. No dependencies.
`default_nettype none

package pdf_pkg;

	localparam int COST_W          = 32;
	localparam int NUM_COST_FIELDS = 4;
	localparam int CFG_W           = 3;
	localparam int IDX_OUT_W       = 6;

	localparam logic [CFG_W-1:0] OBJ_RESET = 3'd3;

	localparam int MAX_POINTS_DEF     = 64;
	localparam int MAX_OBJECTIVES_DEF = 4;

	typedef logic [NUM_COST_FIELDS-1:0][COST_W-1:0] cost_vec_t;

	// broadcast to every cell
	typedef struct packed {
		logic accept;   // a word is stored this cycle; dropped words compare with nothing
		logic shift;    // drain: marks move one cell toward cell 0
		logic clear;    // drain done: population emptied
	} cell_ctrl_t;

	// a dominates b over the first n objectives
	function automatic logic dominates(cost_vec_t a, cost_vec_t b, logic [CFG_W-1:0] n);
		logic worse;
		logic strict;
		worse  = 1'b0;
		strict = 1'b0;
		for (int k = 0; k < NUM_COST_FIELDS; k++) begin
			if (CFG_W'(k) < n) begin
				if ($signed(b[k]) < $signed(a[k])) worse = 1'b1;
				if ($signed(a[k]) < $signed(b[k])) strict = 1'b1;
			end
		end
		return !worse && strict;
	endfunction

endpackage

`default_nettype wire

FILE: src/pdf_cell.sv
// One stored point of the filter: its costs, valid bit and dominated mark.
// Depends on pdf_pkg. Marks chain to the lower neighbor while draining.
`default_nettype none

module pdf_cell #(
	parameter int NOBJ = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pdf_pkg::cell_ctrl_t ctrl,
	input  wire logic               load,
	input  wire pdf_pkg::cost_vec_t new_cost,
	input  wire logic [pdf_pkg::CFG_W-1:0] nobj,
	input  wire logic               new_mark,
	input  wire logic               mark_in,
	output logic                    valid,
	output logic                    mark,
	output logic                    dom_new
);
	import pdf_pkg::*;

	logic [NOBJ-1:0][COST_W-1:0] cost_q;
	logic      valid_q;
	logic      mark_q;
	cost_vec_t cost_full;
	logic      new_dom_me;

	// fields past NOBJ are never compared, pad them
	for (genvar k = 0; k < NUM_COST_FIELDS; k++) begin : g_pad
		if (k < NOBJ) begin : g_st
			assign cost_full[k] = cost_q[k];
		end else begin : g_zero
			assign cost_full[k] = '0;
		end
	end

	assign new_dom_me = valid_q && dominates(new_cost, cost_full, nobj);
	assign dom_new    = valid_q && dominates(cost_full, new_cost, nobj);

	always_ff @(posedge clk) begin
		if (load) begin
			cost_q <= new_cost[NOBJ-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				valid_q <= 1'b0;
			end else if (load) begin
				valid_q <= 1'b1;
			end
			if (load) begin
				mark_q <= new_mark;
			end else if (ctrl.accept && new_dom_me) begin
				mark_q <= 1'b1;
			end else if (ctrl.shift) begin
				mark_q <= mark_in;
			end
		end
	end

	assign valid = valid_q;
	assign mark  = mark_q;

endmodule

`default_nettype wire

FILE: src/pareto_dominance_filter.sv
// Top level of the Pareto dominance filter: a row of pdf_cell, the fill
// counter, the drain sequencer and the objective-count register.
// Depends on pdf_pkg and pdf_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | cost_0..cost_3, final_point
//  output   | out_valid / out_stall| point_index, is_dominated,
//           |                      | population_overflow, last_result
//  config   | cfg_we               | cfg_wdata (active objectives)
//
// A non-final word is broadcast to every cell and compared against all stored
// points at once, so words stream in at one per cycle.
// A final word starts a drain of N results (N stored points), one per cycle
// as the output side takes them; the drain walks the mark chain of the cells.
// in_stall is high for the whole drain. Reset empties the population and
// sets the objective count to 3. Output stalls hold the current result.
`default_nettype none

module pareto_dominance_filter #(
	parameter int MAX_POINTS     = pdf_pkg::MAX_POINTS_DEF,
	parameter int MAX_OBJECTIVES = pdf_pkg::MAX_OBJECTIVES_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [pdf_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [pdf_pkg::COST_W-1:0]  cost_0,
	input  wire logic signed [pdf_pkg::COST_W-1:0]  cost_1,
	input  wire logic signed [pdf_pkg::COST_W-1:0]  cost_2,
	input  wire logic signed [pdf_pkg::COST_W-1:0]  cost_3,
	input  wire logic                               final_point,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [pdf_pkg::IDX_OUT_W-1:0]           point_index,
	output logic                                    is_dominated,
	output logic                                    population_overflow,
	output logic                                    last_result
);
	import pdf_pkg::*;

	localparam int OBJ_CAP = (MAX_OBJECTIVES < NUM_COST_FIELDS) ? MAX_OBJECTIVES
	                                                            : NUM_COST_FIELDS;
	localparam int CNT_W   = $clog2(MAX_POINTS + 1);
	localparam int IDX_W   = $clog2(MAX_POINTS);

	logic [CFG_W-1:0] obj_q;
	logic [CFG_W-1:0] nobj;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic             drain_q;
	logic             ovf_q;
	logic             in_acc;
	logic             out_acc;
	logic             full;
	logic             is_last;
	logic             new_mark;
	cost_vec_t        new_cost;
	cell_ctrl_t       ctrl;

	logic [MAX_POINTS-1:0] load;
	logic [MAX_POINTS-1:0] valid;
	logic [MAX_POINTS-1:0] mark;
	logic [MAX_POINTS-1:0] dom_new;

	always_comb begin
		nobj = obj_q;
		if (obj_q == '0) nobj = CFG_W'(1);
		if (obj_q > CFG_W'(OBJ_CAP)) nobj = CFG_W'(OBJ_CAP);
	end

	assign new_cost = {cost_3, cost_2, cost_1, cost_0};
	assign in_stall = drain_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign full     = (count_q == CNT_W'(MAX_POINTS));
	assign is_last  = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
	assign new_mark = |dom_new;

	assign ctrl.accept = in_acc && !full;
	assign ctrl.shift  = out_acc;
	assign ctrl.clear  = out_acc && is_last;

	for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
		assign load[i] = in_acc && !full && (count_q == CNT_W'(i));
		pdf_cell #(
			.NOBJ(OBJ_CAP)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.load     (load[i]),
			.new_cost (new_cost),
			.nobj     (nobj),
			.new_mark (new_mark),
			.mark_in  ((i == MAX_POINTS - 1) ? 1'b0 : mark[(i + 1) % MAX_POINTS]),
			.valid    (valid[i]),
			.mark     (mark[i]),
			.dom_new  (dom_new[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q <= OBJ_RESET;
		end else if (cfg_we) begin
			obj_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (final_point) begin
					drain_q <= 1'b1;
					idx_q   <= '0;
				end
			end
			if (out_acc) begin
				idx_q <= idx_q + IDX_W'(1);
				if (is_last) begin
					drain_q <= 1'b0;
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// cell 0 always holds the mark of the point being reported
	assign out_valid           = drain_q && valid[0];
	assign point_index         = IDX_OUT_W'(idx_q);
	assign is_dominated        = mark[0];
	assign population_overflow = ovf_q;
	assign last_result         = is_last;

endmodule

`default_nettype wire

FILE: src/pdf_checker.sv
// Port-level checks for pareto_dominance_filter, bound to the top level.
// Depends only on pdf_pkg widths.
`default_nettype none

module pdf_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          final_point,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [pdf_pkg::IDX_OUT_W-1:0] point_index,
	input wire logic                          last_result
);
	import pdf_pkg::*;

	// no word is taken while results drain
	a_stall_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during drain");

	a_first_index: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && final_point |=> out_valid && point_index == '0)
		else $error("drain did not start at index 0");

	a_next_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=>
			out_valid && point_index == IDX_OUT_W'($past(point_index) + IDX_OUT_W'(1)))
		else $error("result index skipped");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_result |=> !out_valid)
		else $error("result after last");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_index))
		else $error("stalled word changed");

endmodule

bind pareto_dominance_filter pdf_checker u_pdf_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for pareto_dominance_filter: queued point driver, result monitor,
// in-bench dominance predictor and phased idling/stall pressure.
// Depends on pdf_pkg and the pareto_dominance_filter RTL.
`default_nettype none

module tb_top;
	import pdf_pkg::*;

	localparam int MAX_PTS       = pdf_pkg::MAX_POINTS_DEF;
	localparam int MAX_OBJ       = pdf_pkg::MAX_OBJECTIVES_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int RX_HOLD_LEN   = 300;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_ITEMS   = 20;

	typedef struct {
		cost_vec_t costs;
		logic      fin;
	} point_word_t;

	typedef struct {
		logic [IDX_OUT_W-1:0] index;
		logic                 dominated;
		logic                 overflow;
		logic                 last;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata = OBJ_RESET;
	logic                 in_valid = 1'b0;
	logic [COST_W-1:0]    cost_0 = '0;
	logic [COST_W-1:0]    cost_1 = '0;
	logic [COST_W-1:0]    cost_2 = '0;
	logic [COST_W-1:0]    cost_3 = '0;
	logic                 final_point = 1'b0;
	logic                 out_stall = 1'b0;
	wire                  in_stall;
	wire                  out_valid;
	wire [IDX_OUT_W-1:0]  point_index;
	wire                  is_dominated;
	wire                  population_overflow;
	wire                  last_result;

	// predictor state
	cost_vec_t        pop_costs [MAX_PTS];
	logic             pop_marks [MAX_PTS];
	int               pop_count = 0;
	logic             pop_overflow = 1'b0;
	logic [CFG_W-1:0] objectives_reg = OBJ_RESET;

	point_word_t point_queue[$];
	verdict_t    expected_verdicts[$];
	point_word_t next_word;
	verdict_t    got_verdict;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_asks = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;
	int cycle_count = 0;
	int error_count = 0;

	pareto_dominance_filter dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.cost_0              (cost_0),
		.cost_1              (cost_1),
		.cost_2              (cost_2),
		.cost_3              (cost_3),
		.final_point         (final_point),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.point_index         (point_index),
		.is_dominated        (is_dominated),
		.population_overflow (population_overflow),
		.last_result         (last_result)
	);

	always #4 clk = ~clk;

	function automatic int objective_span();
		int n;
		int cap;
		n   = int'(objectives_reg);
		cap = (MAX_OBJ < NUM_COST_FIELDS) ? MAX_OBJ : NUM_COST_FIELDS;
		if (n < 1) n = 1;
		if (n > cap) n = cap;
		return n;
	endfunction

	// a beats b: no active objective worse, at least one strictly better
	function automatic logic beats(cost_vec_t a, cost_vec_t b, int n);
		logic strict;
		strict = 1'b0;
		for (int k = 0; k < n; k++) begin
			if ($signed(b[k]) < $signed(a[k])) return 1'b0;
			if ($signed(a[k]) < $signed(b[k])) strict = 1'b1;
		end
		return strict;
	endfunction

	task automatic predict_point(input cost_vec_t p, input logic fin);
		int n;
		verdict_t v;
		n = objective_span();
		if (pop_count < MAX_PTS) begin
			pop_marks[pop_count] = 1'b0;
			for (int j = 0; j < pop_count; j++) begin
				if (beats(p, pop_costs[j], n)) pop_marks[j] = 1'b1;
				if (beats(pop_costs[j], p, n)) pop_marks[pop_count] = 1'b1;
			end
			pop_costs[pop_count] = p;
			pop_count++;
		end else
			pop_overflow = 1'b1;
		if (fin) begin
			for (int j = 0; j < pop_count; j++) begin
				v.index     = IDX_OUT_W'(j);
				v.dominated = pop_marks[j];
				v.overflow  = pop_overflow;
				v.last      = (j == pop_count - 1);
				expected_verdicts.insert(expected_verdicts.size(), v);
			end
			pop_count    = 0;
			pop_overflow = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, want %0d", what, got, want);
		error_count++;
	endtask

	// driver: one word offered at a time, held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_point({cost_3, cost_2, cost_1, cost_0}, final_point);
			if (!in_valid || !in_stall) begin
				if (point_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_word = point_queue.pop_front();
					cost_0      <= next_word.costs[0];
					cost_1      <= next_word.costs[1];
					cost_2      <= next_word.costs[2];
					cost_3      <= next_word.costs[3];
					final_point <= next_word.fin;
					in_valid    <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (rx_hold_seen != rx_hold_asks) begin
			rx_hold_seen <= rx_hold_asks;
			rx_hold_left <= RX_HOLD_LEN;
		end else if (rx_hold_left != 0)
			rx_hold_left <= rx_hold_left - 1;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0)
					report_mismatch("unexpected result, point_index", point_index, -1);
				else begin
					got_verdict = expected_verdicts.pop_front();
					if (point_index !== got_verdict.index)
						report_mismatch("point_index", point_index, got_verdict.index);
					if (is_dominated !== got_verdict.dominated)
						report_mismatch("is_dominated", is_dominated, got_verdict.dominated);
					if (population_overflow !== got_verdict.overflow)
						report_mismatch("population_overflow", population_overflow,
							got_verdict.overflow);
					if (last_result !== got_verdict.last)
						report_mismatch("last_result", last_result, got_verdict.last);
				end
			end
			out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pareto_dominance_filter: mismatch");
			$finish;
		end
	end

	function automatic logic [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2, 3:    return $urandom;
			default: return COST_W'($urandom_range(0, 6)) - 32'd3;
		endcase
	endfunction

	task automatic push_point(input logic [COST_W-1:0] c0, c1, c2, c3, input logic fin);
		point_word_t w;
		w.costs = {c3, c2, c1, c0};
		w.fin   = fin;
		point_queue.insert(point_queue.size(), w);
	endtask

	task automatic push_set(input int count);
		for (int i = 0; i < count; i++)
			push_point(pick_cost(), pick_cost(), pick_cost(), pick_cost(), i == count - 1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (point_queue.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_objectives(input logic [CFG_W-1:0] value);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		objectives_reg = value;
		@(negedge clk);
	endtask

	localparam logic [COST_W-1:0] CMIN = 32'h8000_0000;
	localparam logic [COST_W-1:0] CMAX = 32'h7FFF_FFFF;

	initial begin
		int phase_items;
		int set_len;
		logic [CFG_W-1:0] phase_cfg [4];
		phase_cfg = '{3'd2, 3'd5, 3'd6, 3'd3};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset objective count (3): cost_3 is ignored, equal points tie
		push_point(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		push_point(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
		push_point(CMIN, CMIN, CMIN, CMAX, 1'b0);
		push_point(CMAX, CMAX, CMAX, CMIN, 1'b0);
		push_point(CMIN, CMIN, CMIN, CMIN, 1'b1);
		// set of one word
		push_point(CMAX, CMAX, CMAX, CMAX, 1'b1);

		// zero counts as one objective
		write_objectives(3'd0);
		push_point(32'd5, 32'd9, 32'd0, 32'd0, 1'b0);
		push_point(32'd5, -32'd9, 32'd1, 32'd1, 1'b0);
		push_point(32'd4, CMAX, CMAX, CMAX, 1'b0);
		push_point(32'd6, CMIN, CMIN, CMIN, 1'b1);

		// above range is cut to four
		write_objectives(3'd7);
		push_point(32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
		push_point(32'd1, 32'd1, 32'd1, 32'd0, 1'b0);
		push_point(32'd0, 32'd2, 32'd0, 32'd0, 1'b0);
		push_point(32'd1, 32'd1, 32'd1, 32'd0, 1'b1);

		// count changed in the middle of a set
		write_objectives(3'd1);
		push_point(32'd2, 32'd0, 32'd0, 32'd0, 1'b0);
		push_point(32'd1, 32'd5, 32'd5, 32'd5, 1'b0);
		write_objectives(3'd4);
		push_point(32'd1, 32'd4, 32'd4, 32'd4, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
				default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
			endcase
			write_objectives(phase_cfg[ph]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				if ($urandom_range(0, 3) == 0)
					write_objectives(CFG_W'($urandom_range(0, 7)));
				set_len = ($urandom_range(0, 24) == 0) ? 64 + $urandom_range(0, 3)
					: $urandom_range(1, 10);
				push_set(set_len);
				phase_items += set_len;
			end
		end

		// full population: a word past capacity and the closing word are dropped
		wait_drained();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_objectives(3'd4);
		push_set(66);

		// receiver holds off while the sender keeps offering
		wait_drained();
		write_objectives(3'd2);
		rx_hold_asks++;
		push_set(10);
		push_set(6);
		push_set(3);
		wait_drained();
		tx_idle_pct = 12;
		rx_stall_pct = 12;
		push_set(5);

		wait_drained();
		if (error_count == 0 && expected_verdicts.size() == 0)
			$display("pareto_dominance_filter: match");
		else
			$display("pareto_dominance_filter: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
